// File: hw/rtl/csa_pkg.sv
//------------------------------------------------------------------------------
// csa_pkg
// shared types and constants for the contiguous slot allocator
//------------------------------------------------------------------------------
package csa_pkg;

    localparam int unsigned SLOT_COUNT_DEF    = 256;
    localparam int unsigned TABLE_ENTRIES_DEF = 16;
    localparam int unsigned SECTION_SHIFT_DEF = 20;
    localparam int unsigned ADDR_W            = 32;
    localparam int unsigned LIMIT_W           = 9;
    localparam int unsigned WBASE_W           = 12;
    localparam int unsigned SEC_W             = 9;
    localparam logic [11:0] WBASE_RST         = 12'd3840;
    localparam logic [8:0]  LIMIT_RST         = 9'd256;

    localparam logic       REG_WBASE = 1'b0;
    localparam logic       REG_LIMIT = 1'b1;

    localparam logic       CMD_MAP   = 1'b0;
    localparam logic       CMD_UNMAP = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ARG  = 3'd1;
    localparam logic [2:0] ST_NO_RUN   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN,
        S_ENT_RD,
        S_ENT,
        S_SET,
        S_FIND_RD,
        S_FIND,
        S_FREE,
        S_OUT
    } t_state;

endpackage

// File: hw/rtl/csa_ram.sv
//------------------------------------------------------------------------------
// csa_ram
// generic single-port ram with registered read
//------------------------------------------------------------------------------
module csa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hw/rtl/contiguous_slot_allocator_top.sv
//------------------------------------------------------------------------------
// contiguous_slot_allocator_top
// first-fit allocator of contiguous section windows over a slot bitmap
//------------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tuser=command, tdata=phys_addr,length,virt_addr
// m_axis   out  tdata=status,mapped_addr,window_va,window_pa,window_sections
// cfg      in   we, index (0 window base, 1 slot limit), wdata
// one item at a time; map scans the slot bitmap ram slot by slot, a read state
// then a check state per slot, then takes a free table entry and marks the run;
// unmap scans the entry table then frees the run
// after reset a clearing pass over all SLOT_COUNT slots empties the bitmap ram
// the entry table uses flip-flop valid bits
// a result holds in the output register until taken; next item waits for it
//------------------------------------------------------------------------------
module contiguous_slot_allocator_top
    import csa_pkg::*;
#(
    parameter int unsigned SLOT_COUNT    = SLOT_COUNT_DEF,
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned SECTION_SHIFT = SECTION_SHIFT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [11:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // phys_addr, length, virt_addr
    input  logic         s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata   // status, mapped_addr, window_va,
                                        // window_pa, window_sections, zero pad
);
    localparam int unsigned SW = $clog2(SLOT_COUNT);
    localparam int unsigned EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = SW + 1;
    localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [ADDR_W-1:0] SEC_MASK = ADDR_W'((64'd1 << SECTION_SHIFT) - 64'd1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOT_COUNT);

    t_state r_state, n_state;
    logic [WBASE_W-1:0] r_wbase;
    logic [LIMIT_W-1:0] r_limit;
    logic r_cmd;
    logic [ADDR_W-1:0] r_pa, r_va, r_off;
    logic [ADDR_W:0] r_nsec;
    logic [CW-1:0] r_idx, n_idx, r_run, n_run, r_start, n_start, r_end, n_end;
    logic [EW:0] r_eidx, n_eidx;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [2:0] r_st, n_st;
    logic [ADDR_W-1:0] r_mapped, n_mapped, r_wva, n_wva, r_wpa, n_wpa;
    logic [SEC_W-1:0] r_wsec, n_wsec;
    logic r_ovalid, n_ovalid;

    logic bm_we, bm_wd, bm_rd;
    logic [SW-1:0] bm_addr;
    logic et_we;
    logic [EW-1:0] et_addr;
    logic [ADDR_W*2+SEC_W+CW-1:0] et_wd, et_rd;
    logic [ADDR_W-1:0] et_va, et_pa;
    logic [SEC_W-1:0] et_sec;
    logic [CW-1:0] et_slot;
    logic [CW-1:0] lim;
    logic [ADDR_W:0] total;
    logic [ADDR_W-1:0] va_calc;

    csa_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_addr(bm_addr), .i_wdata(bm_wd), .o_rdata(bm_rd)
    );
    csa_ram #(.WIDTH(ADDR_W*2+SEC_W+CW), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk(i_clk), .i_we(et_we), .i_addr(et_addr), .i_wdata(et_wd), .o_rdata(et_rd)
    );

    assign {et_va, et_pa, et_sec, et_slot} = et_rd;
    assign lim = (LW'(r_limit) > LW'(SLOTS_C)) ? SLOTS_C : CW'(r_limit);
    assign total = {1'b0, s_axis_tdata[63:32]} + {1'b0, s_axis_tdata[31:0] & SEC_MASK};
    assign va_calc = ADDR_W'({20'd0, r_wbase} << SECTION_SHIFT)
                   + ADDR_W'({{(ADDR_W){1'b0}}, r_start} << SECTION_SHIFT);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {4'd0, r_wsec, r_wpa, r_wva, r_mapped, r_st};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_wbase <= WBASE_RST;
            r_limit <= LIMIT_RST;
            r_valid <= '0;
            r_ovalid <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_ovalid <= n_ovalid;
            r_idx <= n_idx;
            if (i_cfg_we && i_cfg_index == REG_WBASE) r_wbase <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_index == REG_LIMIT) r_limit <= i_cfg_wdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_run <= n_run; r_start <= n_start; r_end <= n_end; r_eidx <= n_eidx;
        r_st <= n_st; r_mapped <= n_mapped; r_wva <= n_wva; r_wpa <= n_wpa;
        r_wsec <= n_wsec;
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tuser;
            r_pa <= s_axis_tdata[31:0] & ~SEC_MASK;
            r_off <= s_axis_tdata[31:0] & SEC_MASK;
            r_va <= s_axis_tdata[95:64];
            r_nsec <= (total + {1'b0, SEC_MASK}) >> SECTION_SHIFT;
        end
    end

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_run = r_run; n_start = r_start;
        n_end = r_end; n_eidx = r_eidx; n_valid = r_valid; n_st = r_st;
        n_mapped = r_mapped; n_wva = r_wva; n_wpa = r_wpa; n_wsec = r_wsec;
        n_ovalid = r_ovalid && !m_axis_tready;
        bm_we = 1'b0; bm_wd = 1'b0; bm_addr = r_idx[SW-1:0];
        et_we = 1'b0; et_addr = r_eidx[EW-1:0]; et_wd = '0;
        case (r_state)
            S_CLEAR: begin
                bm_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == SLOTS_C - 1'b1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_st = ST_OK; n_mapped = '0; n_wva = '0; n_wpa = '0; n_wsec = '0;
                    n_idx = '0; n_run = '0; n_eidx = '0;
                    if (s_axis_tuser == CMD_MAP) begin
                        if (s_axis_tdata[63:32] == '0) begin
                            n_st = ST_BAD_ARG; n_state = S_OUT;
                        end else n_state = S_SCAN_RD;
                    end else begin
                        if (s_axis_tdata[95:64] == '0) begin
                            n_st = ST_BAD_ARG; n_state = S_OUT;
                        end else n_state = S_FIND_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_nsec > {{(ADDR_W+1-CW){1'b0}}, lim} || r_idx >= lim) begin
                    n_st = ST_NO_RUN; n_state = S_OUT;
                end else n_state = S_SCAN;
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                n_state = S_SCAN_RD;
                if (!bm_rd) begin
                    n_run = r_run + 1'b1;
                    if ({{(ADDR_W+1-CW){1'b0}}, n_run} == r_nsec) begin
                        n_start = r_idx + 1'b1 - n_run;
                        n_state = S_ENT;
                        n_eidx = '0;
                    end
                end else n_run = '0;
            end
            S_ENT: begin
                if (r_eidx == (EW+1)'(TABLE_ENTRIES)) begin
                    n_st = ST_FULL; n_state = S_OUT;
                end else if (!r_valid[r_eidx[EW-1:0]]) begin
                    et_we = 1'b1;
                    et_wd = {va_calc, r_pa, SEC_W'(r_nsec), r_start};
                    n_valid[r_eidx[EW-1:0]] = 1'b1;
                    n_wva = va_calc; n_wpa = r_pa; n_wsec = SEC_W'(r_nsec);
                    n_mapped = va_calc + r_off;
                    n_idx = r_start; n_end = r_start + CW'(r_nsec);
                    n_state = S_SET;
                end else n_eidx = r_eidx + 1'b1;
            end
            S_SET: begin
                bm_we = 1'b1; bm_wd = r_cmd == CMD_MAP;
                n_idx = r_idx + 1'b1;
                if (n_idx == r_end || n_idx == SLOTS_C) n_state = S_OUT;
            end
            S_FIND_RD: begin
                if (r_eidx == (EW+1)'(TABLE_ENTRIES)) begin
                    n_st = ST_NOT_FOUND; n_state = S_OUT;
                end else n_state = S_FIND;
            end
            S_FIND: begin
                if (r_valid[r_eidx[EW-1:0]] && et_va == (r_va & ~SEC_MASK)) begin
                    n_valid[r_eidx[EW-1:0]] = 1'b0;
                    n_wva = et_va; n_wpa = et_pa; n_wsec = et_sec;
                    n_idx = et_slot; n_end = et_slot + CW'(et_sec);
                    n_state = (et_sec == '0) ? S_OUT : S_FREE;
                end else begin
                    n_eidx = r_eidx + 1'b1; n_state = S_FIND_RD;
                end
            end
            S_FREE: begin
                bm_we = 1'b1; bm_wd = 1'b0;
                n_idx = r_idx + 1'b1;
                if (n_idx == r_end || n_idx == SLOTS_C) n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("accept while busy");
    a_ok_has_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_st == ST_OK |-> r_wsec != '0) else $error("empty window");
endmodule

// File: verif/contiguous_slot_allocator_top_test.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// contiguous_slot_allocator_top_test
// checks map and unmap results of the slot allocator against a built-in
// predictor of the slot bitmap and window table, under random idling and stalls
//------------------------------------------------------------------------------
module contiguous_slot_allocator_top_test
    import csa_pkg::*;
();

    localparam int NSLOT = 256;
    localparam int NENT  = 16;
    localparam int SHIFT = 20;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] mapped_addr;
        logic [31:0] window_va;
        logic [31:0] window_pa;
        logic [8:0]  window_sections;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [11:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;  // phys_addr, length, virt_addr
    logic         s_axis_tuser;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;  // status, mapped_addr, window_va, window_pa,
                                 // window_sections, zero pad

    contiguous_slot_allocator_top i_dut (.*);

    // predictor state
    logic [11:0] wbase;
    logic [8:0]  slimit;
    bit          slot_busy [NSLOT];
    bit          win_valid [NENT];
    logic [31:0] win_va [NENT];
    logic [31:0] win_pa [NENT];
    int          win_secs [NENT];
    int          win_slot [NENT];

    t_answer     answers_due [$];
    logic [31:0] live_va [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          fails;
    int          cycles;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_answer allocate_window(logic cmd, logic [31:0] pa,
                                                logic [31:0] len, logic [31:0] va);
        t_answer a;
        int lim, need, run, start, e;
        longint base, off, nsec;
        logic [31:0] vb;
        a = '0;
        lim = (slimit > NSLOT) ? NSLOT : int'(slimit);
        if (cmd == CMD_MAP) begin
            base = longint'(pa) & ~((64'd1 << SHIFT) - 1);
            off = longint'(pa) - base;
            nsec = (longint'(len) + off + (64'd1 << SHIFT) - 1) >> SHIFT;
            if (len == 0) begin
                a.status = ST_BAD_ARG;
                return a;
            end
            start = -1;
            if (nsec <= lim) begin
                need = int'(nsec);
                run = 0;
                for (int i = 0; i < lim && start < 0; i++) begin
                    if (!slot_busy[i]) begin
                        run++;
                        if (run == need) start = i + 1 - need;
                    end else begin
                        run = 0;
                    end
                end
            end
            if (start < 0) begin
                a.status = ST_NO_RUN;
                return a;
            end
            e = -1;
            for (int i = NENT - 1; i >= 0; i--) if (!win_valid[i]) e = i;
            if (e < 0) begin
                a.status = ST_FULL;
                return a;
            end
            vb = (32'(wbase) << SHIFT) + (32'(start) << SHIFT);
            for (int i = 0; i < need; i++) slot_busy[start + i] = 1'b1;
            win_valid[e] = 1'b1;
            win_va[e] = vb;
            win_pa[e] = 32'(base);
            win_secs[e] = need;
            win_slot[e] = start;
            a.status = ST_OK;
            a.mapped_addr = vb + 32'(off);
            a.window_va = vb;
            a.window_pa = 32'(base);
            a.window_sections = 9'(need);
        end else begin
            if (va == 0) begin
                a.status = ST_BAD_ARG;
                return a;
            end
            vb = va & ~((32'd1 << SHIFT) - 1);
            e = -1;
            for (int i = NENT - 1; i >= 0; i--) if (win_valid[i] && win_va[i] == vb) e = i;
            if (e < 0) begin
                a.status = ST_NOT_FOUND;
                return a;
            end
            for (int i = 0; i < win_secs[e]; i++) slot_busy[win_slot[e] + i] = 1'b0;
            a.status = ST_OK;
            a.window_va = win_va[e];
            a.window_pa = win_pa[e];
            a.window_sections = 9'(win_secs[e]);
            win_valid[e] = 1'b0;
        end
        return a;
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_answer got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[2:0];
            got.mapped_addr = m_axis_tdata[34:3];
            got.window_va = m_axis_tdata[66:35];
            got.window_pa = m_axis_tdata[98:67];
            got.window_sections = m_axis_tdata[107:99];
            if (answers_due.size() == 0) begin
                $error("result with no item pending");
                fails++;
            end else begin
                want = answers_due.pop_front();
                if (got.status != want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); fails++;
                end
                if (got.mapped_addr != want.mapped_addr) begin
                    $error("mapped_addr exp %h got %h", want.mapped_addr, got.mapped_addr);
                    fails++;
                end
                if (got.window_va != want.window_va) begin
                    $error("window_va exp %h got %h", want.window_va, got.window_va); fails++;
                end
                if (got.window_pa != want.window_pa) begin
                    $error("window_pa exp %h got %h", want.window_pa, got.window_pa); fails++;
                end
                if (got.window_sections != want.window_sections) begin
                    $error("window_sections exp %0d got %0d", want.window_sections,
                           got.window_sections);
                    fails++;
                end
                if (want.status == ST_OK && want.mapped_addr != 0)
                    live_va.push_back(want.mapped_addr);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(logic cmd, logic [31:0] pa, logic [31:0] len,
                             logic [31:0] va);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {va, len, pa};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        answers_due.push_back(allocate_window(cmd, pa, len, va));
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == REG_WBASE) wbase = val;
        else slimit = val[8:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic unmap_some();
        int k;
        logic [31:0] va;
        k = $urandom_range(live_va.size() > 0 ? live_va.size() - 1 : 0);
        va = (live_va.size() > 0) ? live_va[k] : $urandom;
        if (live_va.size() > 0) live_va.delete(k);
        if ($urandom_range(9) == 0) va = $urandom;
        send_item(CMD_UNMAP, 32'd0, $urandom, va);
    endtask

    task automatic random_item();
        logic [31:0] len;
        case ($urandom_range(9))
            0: len = $urandom;
            1: len = 32'd0;
            2: len = $urandom_range(32'h0400_0000);
            default: len = $urandom_range(32'h0030_0000);
        endcase
        if ($urandom_range(99) < 45) unmap_some();
        else send_item(CMD_MAP, $urandom, len, $urandom);
    endtask

    task automatic test_directed();
        send_item(CMD_MAP, 32'h0000_0000, 32'd1, 32'd0);
        send_item(CMD_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_MAP, 32'h1234_5678, 32'd0, 32'd0);
        send_item(CMD_MAP, 32'hFFFF_FFFF, 32'd1, 32'd0);
        send_item(CMD_MAP, 32'h000F_FFFF, 32'd2, 32'd0);
        send_item(CMD_MAP, 32'h4000_0000, 32'h1000_0000, 32'd0);
        send_item(CMD_MAP, 32'h4000_0000, 32'h0FF0_0000, 32'd0);
        send_item(CMD_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_UNMAP, 32'd0, 32'd0, 32'h0000_1000);
        while (live_va.size() != 0 || answers_due.size() != 0) begin
            if (live_va.size() != 0) unmap_some();
            else @(negedge i_clk);
        end
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NENT + 2; i++) send_item(CMD_MAP, $urandom, 32'd1, 32'd0);
        send_item(CMD_MAP, 32'd0, 32'h1000_0000, 32'd0);
        while (answers_due.size() != 0) @(negedge i_clk);
        while (live_va.size() != 0) unmap_some();
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) random_item();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 2000;
        for (int i = 0; i < 20; i++) random_item();
    endtask

    task automatic test_config_sweep();
        write_reg(REG_WBASE, 12'hFFF);
        write_reg(REG_LIMIT, 9'd0);
        for (int i = 0; i < 10; i++) random_item();
        write_reg(REG_LIMIT, 9'h1FF);
        test_random(100, 27, 27);
        write_reg(REG_WBASE, 12'd0);
        write_reg(REG_LIMIT, 9'd8);
        test_random(100, 0, 0);
        write_reg(REG_WBASE, 12'd4000);
        write_reg(REG_LIMIT, 9'd256);
        test_random(100, 64, 0);
    endtask

    initial begin
        i_clk = 1'b0;
        cycles = 0;
        fails = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wbase = WBASE_RST;
        slimit = LIMIT_RST;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(150, 0, 0);
        test_random(150, 64, 0);
        test_random(150, 0, 64);
        test_random(150, 27, 27);
        test_config_sweep();
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
